// ----- sv/mtt_pkg.sv -----
package mtt_pkg;

    localparam int AXES_DEF      = 8;
    localparam int TEMP_BITS_DEF = 24;

    localparam int AXIS_BITS     = 3;
    localparam int DAC_BITS      = 16;
    localparam int COEF_BITS     = 32;
    localparam int LIM_BITS      = 24;
    localparam int USE_BITS      = 4;
    localparam int OUT_BITS      = 24;
    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 32;

    // radix-4 serial multiply: two multiplier bits retire per cycle while step is high
    localparam int DIGIT_BITS    = 2;
    // heat term is the squared-drive product scaled down by 2^20
    localparam int HEAT_SHIFT    = 20;

    localparam int AIR_RESET     = 102400;
    localparam int OVER_RESET    = 409600;
    localparam int COOL_RESET    = 245760;
    localparam int USE_RESET     = 8;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_COEF_HEAT,
        REG_CORE_LOSS,
        REG_CASE_GAIN,
        REG_CASE_LOSS,
        REG_AIR_TEMP,
        REG_OVER_LIMIT,
        REG_COOL_LIMIT,
        REG_AXES_IN_USE
    } cfg_reg_t;

    typedef struct packed {
        logic load;
        logic step;
    } mul_ctl_t;

endpackage

// ----- sv/mtt_smul.sv -----
// Radix-4 shift-add multiplier: multiplier digits leave at the bottom of
// lo_reg while finished product bits enter at its top.
module mtt_smul
    import mtt_pkg::*;
#(
    parameter int MCAND_BITS  = 16,
    parameter int MPLIER_BITS = 16
)
(
    input  logic                              clk,
    input  mul_ctl_t                          ctl,
    input  logic [MCAND_BITS-1:0]             mcand,
    input  logic [MPLIER_BITS-1:0]            mplier,
    output logic [MCAND_BITS+MPLIER_BITS-1:0] prod
);

    logic [MCAND_BITS-1:0]  mc_reg;
    logic [MCAND_BITS-1:0]  acc_reg;
    logic [MCAND_BITS-1:0]  acc_next;
    logic [MPLIER_BITS-1:0] lo_reg;
    logic [MPLIER_BITS-1:0] lo_next;
    logic [MCAND_BITS+1:0]  sum;

    always_comb
    begin
        sum = {2'b00, acc_reg}
            + (lo_reg[0] ? {2'b00, mc_reg} : '0)
            + (lo_reg[1] ? {1'b0, mc_reg, 1'b0} : '0);
        acc_next = sum[MCAND_BITS+1:DIGIT_BITS];
        lo_next  = {sum[DIGIT_BITS-1:0], lo_reg[MPLIER_BITS-1:DIGIT_BITS]};
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            mc_reg  <= mcand;
            acc_reg <= '0;
            lo_reg  <= mplier;
        end
        else if (ctl.step)
        begin
            acc_reg <= acc_next;
            lo_reg  <= lo_next;
        end
    end

    assign prod = {acc_reg, lo_reg};

endmodule

// ----- sv/motor_thermal_model_tracker_unit.sv -----
// Channel  | Direction | Handshake              | Word
// ---------+-----------+------------------------+-----------------------------------------
// input    | in        | in_valid / in_ready    | axis, dac_value, restart
// result   | out       | out_valid / out_ready  | core_temp, case_temp, over_heated, cooled
// config   | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One word runs from acceptance to the next acceptance through an 8-step
// radix-4 square of the drive value, then 16 radix-4 steps of the four shared
// coefficient multiplies, plus load, rounding and update states.
// The temperature flops reset straight to the ambient reset value; no clearing pass.
// A result waiting in the output register does not block the next input word;
// the update cycle holds until the output register is free.
module motor_thermal_model_tracker_unit
    import mtt_pkg::*;
#(
    parameter int AXES      = AXES_DEF,
    parameter int TEMP_BITS = TEMP_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [AXIS_BITS-1:0]        axis,
    input  logic signed [DAC_BITS-1:0]  dac_value,
    input  logic                        restart,

    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [OUT_BITS-1:0]  core_temp,
    output logic signed [OUT_BITS-1:0]  case_temp,
    output logic                        over_heated,
    output logic                        cooled,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int AXW       = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int MAGW      = TEMP_BITS + 1;
    localparam int SQW       = 2 * DAC_BITS - 1;
    localparam int HEAT_PROD = SQW + COEF_BITS;
    localparam int HEATW     = HEAT_PROD - HEAT_SHIFT;
    localparam int SUMW      = HEATW + 2;
    localparam int CMPW      = 33;
    localparam int IXW       = 5;
    localparam int SQ_STEPS  = DAC_BITS / DIGIT_BITS;
    localparam int MUL_STEPS = COEF_BITS / DIGIT_BITS;
    localparam int CNTW      = $clog2(MUL_STEPS);

    localparam logic [CNTW-1:0] SQ_LAST  = CNTW'(SQ_STEPS - 1);
    localparam logic [CNTW-1:0] MUL_LAST = CNTW'(MUL_STEPS - 1);
    localparam logic [IXW-1:0]  AXES_IX  = IXW'(AXES);

    localparam longint T_MAX_L   = (longint'(1) <<< (TEMP_BITS - 1)) - 1;
    localparam longint T_MIN_L   = -T_MAX_L - 1;
    localparam longint AIR_RST_L = (AIR_RESET > T_MAX_L) ? T_MAX_L :
                                   ((AIR_RESET < T_MIN_L) ? T_MIN_L : AIR_RESET);

    localparam logic signed [TEMP_BITS-1:0] T_MAX_T   = TEMP_BITS'(T_MAX_L);
    localparam logic signed [TEMP_BITS-1:0] T_MIN_T   = TEMP_BITS'(T_MIN_L);
    localparam logic signed [TEMP_BITS-1:0] AIR_RST_T = TEMP_BITS'(AIR_RST_L);
    localparam logic signed [SUMW-1:0]      S_MAX     = SUMW'(T_MAX_L);
    localparam logic signed [SUMW-1:0]      S_MIN     = SUMW'(T_MIN_L);
    localparam logic signed [CMPW-1:0]      C_MAX     = CMPW'(T_MAX_L);
    localparam logic signed [CMPW-1:0]      C_MIN     = CMPW'(T_MIN_L);
    localparam logic signed [CMPW-1:0]      O_MAX     = CMPW'((longint'(1) <<< (OUT_BITS - 1)) - 1);
    localparam logic signed [CMPW-1:0]      O_MIN     = -O_MAX - CMPW'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SQ,
        ST_HLD,
        ST_MUL,
        ST_RND,
        ST_DONE
    } state_t;

    function automatic logic signed [TEMP_BITS-1:0] sat_sum(input logic signed [SUMW-1:0] v);
        logic signed [TEMP_BITS-1:0] r;
        if (v > S_MAX)
            r = T_MAX_T;
        else if (v < S_MIN)
            r = T_MIN_T;
        else
            r = v[TEMP_BITS-1:0];
        return r;
    endfunction

    function automatic logic signed [TEMP_BITS-1:0] sat_cmp(input logic signed [CMPW-1:0] v);
        logic signed [TEMP_BITS-1:0] r;
        if (v > C_MAX)
            r = T_MAX_T;
        else if (v < C_MIN)
            r = T_MIN_T;
        else
            r = v[TEMP_BITS-1:0];
        return r;
    endfunction

    function automatic logic signed [OUT_BITS-1:0] sat_out(input logic signed [TEMP_BITS-1:0] v);
        logic signed [CMPW-1:0] w;
        logic signed [OUT_BITS-1:0] r;
        w = CMPW'(v);
        if (w > O_MAX)
            r = O_MAX[OUT_BITS-1:0];
        else if (w < O_MIN)
            r = O_MIN[OUT_BITS-1:0];
        else
            r = w[OUT_BITS-1:0];
        return r;
    endfunction

    function automatic logic at_or_above(input logic signed [TEMP_BITS-1:0] t,
                                         input logic signed [LIM_BITS-1:0] lim);
        logic signed [CMPW-1:0] tw;
        logic signed [CMPW-1:0] lw;
        tw = CMPW'(t);
        lw = CMPW'(lim);
        return tw >= lw;
    endfunction

    // configuration registers
    logic [COEF_BITS-1:0]        coef_heat_reg;
    logic [COEF_BITS-1:0]        coef_core_loss_reg;
    logic [COEF_BITS-1:0]        coef_case_gain_reg;
    logic [COEF_BITS-1:0]        coef_case_loss_reg;
    logic signed [LIM_BITS-1:0]  air_temp_reg;
    logic signed [LIM_BITS-1:0]  over_limit_reg;
    logic signed [LIM_BITS-1:0]  cool_limit_reg;
    logic [USE_BITS-1:0]         axes_in_use_reg;

    // per-axis state
    logic signed [TEMP_BITS-1:0] core_temps_reg [AXES];
    logic signed [TEMP_BITS-1:0] case_temps_reg [AXES];

    // control
    state_t                      state_reg;
    logic [CNTW-1:0]             cnt_reg;
    logic                        over_acc_reg;
    logic                        warm_acc_reg;
    logic                        out_valid_reg;
    logic signed [OUT_BITS-1:0]  core_out_reg;
    logic signed [OUT_BITS-1:0]  case_out_reg;
    logic                        over_out_reg;
    logic                        cooled_out_reg;

    // item datapath
    logic [AXIS_BITS-1:0]        axis_reg;
    logic [DAC_BITS-1:0]         mag_reg;
    logic                        restart_reg;
    logic signed [TEMP_BITS-1:0] core_reg;
    logic signed [TEMP_BITS-1:0] case_reg;
    logic                        dneg_reg;
    logic                        eneg_reg;
    logic [HEATW-1:0]            heat_reg;
    logic signed [MAGW:0]        fl1_reg;
    logic signed [MAGW:0]        fl2_reg;
    logic signed [MAGW:0]        fl3_reg;

    logic [DAC_BITS-1:0]         dac_mag;
    logic [IXW-1:0]              use_n;
    logic                        axis_lt;
    logic                        in_use;
    logic [AXW-1:0]              rd_idx;
    logic signed [TEMP_BITS-1:0] rd_core;
    logic signed [TEMP_BITS-1:0] rd_case;
    logic signed [TEMP_BITS-1:0] air_t;
    logic signed [MAGW-1:0]      d_val;
    logic signed [MAGW-1:0]      e_val;
    logic [MAGW-1:0]             d_mag;
    logic [MAGW-1:0]             e_mag;
    logic                        sweep_hit;
    logic signed [SUMW-1:0]      core_ext;
    logic signed [SUMW-1:0]      case_ext;
    logic signed [SUMW-1:0]      heat_ext;
    logic signed [SUMW-1:0]      fl1_ext;
    logic signed [SUMW-1:0]      fl2_ext;
    logic signed [SUMW-1:0]      fl3_ext;
    logic signed [SUMW-1:0]      core_sum;
    logic signed [SUMW-1:0]      case_sum;
    logic signed [TEMP_BITS-1:0] core_next;
    logic signed [TEMP_BITS-1:0] case_next;
    logic signed [TEMP_BITS-1:0] core_rep;
    logic signed [TEMP_BITS-1:0] case_rep;
    logic                        over_now;
    logic                        warm_now;
    logic                        proceed;

    mul_ctl_t                    sq_ctl;
    mul_ctl_t                    heat_ctl;
    mul_ctl_t                    flow_ctl;
    logic [2*DAC_BITS-1:0]       sq_prod;
    logic [HEAT_PROD-1:0]        heat_prod;
    logic [MAGW+COEF_BITS-1:0]   fl1_prod;
    logic [MAGW+COEF_BITS-1:0]   fl2_prod;
    logic [MAGW+COEF_BITS-1:0]   fl3_prod;
    logic [MAGW-1:0]             fl1_mag;
    logic [MAGW-1:0]             fl2_mag;
    logic [MAGW-1:0]             fl3_mag;

    assign in_ready    = (state_reg == ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign core_temp   = core_out_reg;
    assign case_temp   = case_out_reg;
    assign over_heated = over_out_reg;
    assign cooled      = cooled_out_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_heat_reg      <= '0;
            coef_core_loss_reg <= '0;
            coef_case_gain_reg <= '0;
            coef_case_loss_reg <= '0;
            air_temp_reg       <= LIM_BITS'(AIR_RESET);
            over_limit_reg     <= LIM_BITS'(OVER_RESET);
            cool_limit_reg     <= LIM_BITS'(COOL_RESET);
            axes_in_use_reg    <= USE_BITS'(USE_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_COEF_HEAT:   coef_heat_reg      <= cfg_data[COEF_BITS-1:0];
                REG_CORE_LOSS:   coef_core_loss_reg <= cfg_data[COEF_BITS-1:0];
                REG_CASE_GAIN:   coef_case_gain_reg <= cfg_data[COEF_BITS-1:0];
                REG_CASE_LOSS:   coef_case_loss_reg <= cfg_data[COEF_BITS-1:0];
                REG_AIR_TEMP:    air_temp_reg       <= cfg_data[LIM_BITS-1:0];
                REG_OVER_LIMIT:  over_limit_reg     <= cfg_data[LIM_BITS-1:0];
                REG_COOL_LIMIT:  cool_limit_reg     <= cfg_data[LIM_BITS-1:0];
                REG_AXES_IN_USE: axes_in_use_reg    <= cfg_data[USE_BITS-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        dac_mag = dac_value[DAC_BITS-1] ? DAC_BITS'(-dac_value) : DAC_BITS'(dac_value);
        use_n   = (IXW'(axes_in_use_reg) > AXES_IX) ? AXES_IX : IXW'(axes_in_use_reg);
        axis_lt = IXW'(axis_reg) < AXES_IX;
        in_use  = IXW'(axis_reg) < use_n;
        air_t   = sat_cmp(CMPW'(air_temp_reg));

        // one read port: the axis at load, the sweep counter otherwise
        if (state_reg == ST_LOAD)
            rd_idx = axis_lt ? AXW'(axis_reg) : '0;
        else
            rd_idx = (IXW'(cnt_reg) < AXES_IX) ? AXW'(cnt_reg) : '0;
        rd_core = core_temps_reg[rd_idx];
        rd_case = case_temps_reg[rd_idx];

        d_val = MAGW'(rd_core) - MAGW'(rd_case);
        e_val = MAGW'(rd_case) - MAGW'(air_t);
        d_mag = d_val[MAGW-1] ? MAGW'(-d_val) : MAGW'(d_val);
        e_mag = e_val[MAGW-1] ? MAGW'(-e_val) : MAGW'(e_val);

        // the ticked axis is checked with its new value at the update cycle
        sweep_hit = (IXW'(cnt_reg) < use_n) && (IXW'(cnt_reg) != IXW'(axis_reg));

        // round half up on the magnitudes
        fl1_mag = fl1_prod[MAGW+COEF_BITS-1:COEF_BITS] + MAGW'(fl1_prod[COEF_BITS-1]);
        fl2_mag = fl2_prod[MAGW+COEF_BITS-1:COEF_BITS] + MAGW'(fl2_prod[COEF_BITS-1]);
        fl3_mag = fl3_prod[MAGW+COEF_BITS-1:COEF_BITS] + MAGW'(fl3_prod[COEF_BITS-1]);

        core_ext = SUMW'(core_reg);
        case_ext = SUMW'(case_reg);
        heat_ext = SUMW'(heat_reg);
        fl1_ext  = SUMW'(fl1_reg);
        fl2_ext  = SUMW'(fl2_reg);
        fl3_ext  = SUMW'(fl3_reg);
        core_sum = core_ext + heat_ext - fl1_ext;
        case_sum = case_ext + fl2_ext - fl3_ext;

        core_next = restart_reg ? air_t : sat_sum(core_sum);
        case_next = restart_reg ? air_t : sat_sum(case_sum);

        if (in_use)
        begin
            core_rep = core_next;
            case_rep = case_next;
        end
        else if (axis_lt)
        begin
            core_rep = core_reg;
            case_rep = case_reg;
        end
        else
        begin
            core_rep = '0;
            case_rep = '0;
        end

        over_now = over_acc_reg | (in_use & at_or_above(core_next, over_limit_reg));
        warm_now = warm_acc_reg | (in_use & at_or_above(core_next, cool_limit_reg));
        proceed  = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

        sq_ctl.load   = (state_reg == ST_LOAD);
        sq_ctl.step   = (state_reg == ST_SQ);
        heat_ctl.load = (state_reg == ST_HLD);
        heat_ctl.step = (state_reg == ST_MUL);
        flow_ctl.load = (state_reg == ST_LOAD);
        flow_ctl.step = (state_reg == ST_MUL);
    end

    mtt_smul #(.MCAND_BITS(DAC_BITS), .MPLIER_BITS(DAC_BITS)) u_sq (
        .clk    (clk),
        .ctl    (sq_ctl),
        .mcand  (mag_reg),
        .mplier (mag_reg),
        .prod   (sq_prod)
    );

    mtt_smul #(.MCAND_BITS(SQW), .MPLIER_BITS(COEF_BITS)) u_heat (
        .clk    (clk),
        .ctl    (heat_ctl),
        .mcand  (sq_prod[SQW-1:0]),
        .mplier (coef_heat_reg),
        .prod   (heat_prod)
    );

    mtt_smul #(.MCAND_BITS(MAGW), .MPLIER_BITS(COEF_BITS)) u_fl1 (
        .clk    (clk),
        .ctl    (flow_ctl),
        .mcand  (d_mag),
        .mplier (coef_core_loss_reg),
        .prod   (fl1_prod)
    );

    mtt_smul #(.MCAND_BITS(MAGW), .MPLIER_BITS(COEF_BITS)) u_fl2 (
        .clk    (clk),
        .ctl    (flow_ctl),
        .mcand  (d_mag),
        .mplier (coef_case_gain_reg),
        .prod   (fl2_prod)
    );

    mtt_smul #(.MCAND_BITS(MAGW), .MPLIER_BITS(COEF_BITS)) u_fl3 (
        .clk    (clk),
        .ctl    (flow_ctl),
        .mcand  (e_mag),
        .mplier (coef_case_loss_reg),
        .prod   (fl3_prod)
    );

    // item datapath
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            axis_reg    <= axis;
            mag_reg     <= dac_mag;
            restart_reg <= restart;
        end
        if (state_reg == ST_LOAD)
        begin
            core_reg <= rd_core;
            case_reg <= rd_case;
            dneg_reg <= d_val[MAGW-1];
            eneg_reg <= e_val[MAGW-1];
        end
        if (state_reg == ST_RND)
        begin
            heat_reg <= heat_prod[HEAT_PROD-1:HEAT_SHIFT] + HEATW'(heat_prod[HEAT_SHIFT-1]);
            fl1_reg  <= dneg_reg ? -$signed({1'b0, fl1_mag}) : $signed({1'b0, fl1_mag});
            fl2_reg  <= dneg_reg ? -$signed({1'b0, fl2_mag}) : $signed({1'b0, fl2_mag});
            fl3_reg  <= eneg_reg ? -$signed({1'b0, fl3_mag}) : $signed({1'b0, fl3_mag});
        end
    end

    // per-axis temperatures
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                core_temps_reg[i] <= AIR_RST_T;
                case_temps_reg[i] <= AIR_RST_T;
            end
        end
        else if (proceed && in_use)
        begin
            core_temps_reg[AXW'(axis_reg)] <= core_next;
            case_temps_reg[AXW'(axis_reg)] <= case_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            over_acc_reg   <= 1'b0;
            warm_acc_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            core_out_reg   <= '0;
            case_out_reg   <= '0;
            over_out_reg   <= 1'b0;
            cooled_out_reg <= 1'b0;
        end
        else
        begin
            if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                        state_reg <= ST_LOAD;
                end
                ST_LOAD:
                begin
                    cnt_reg      <= '0;
                    over_acc_reg <= 1'b0;
                    warm_acc_reg <= 1'b0;
                    state_reg    <= ST_SQ;
                end
                ST_SQ:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == SQ_LAST)
                        state_reg <= ST_HLD;
                end
                ST_HLD:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    // sweep the other axes against the limits, one per cycle
                    if (sweep_hit)
                    begin
                        over_acc_reg <= over_acc_reg | at_or_above(rd_core, over_limit_reg);
                        warm_acc_reg <= warm_acc_reg | at_or_above(rd_core, cool_limit_reg);
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == MUL_LAST)
                        state_reg <= ST_RND;
                end
                ST_RND:
                begin
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    // hold until the output register frees up
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        core_out_reg   <= sat_out(core_rep);
                        case_out_reg   <= sat_out(case_rep);
                        over_out_reg   <= over_now;
                        cooled_out_reg <= !warm_now;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_accept_starts_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_LOAD)
        else $error("accepted word did not start a load");

    a_result_from_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result appeared without an update cycle");

    a_heat_after_square: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_HLD |-> $past(state_reg) == ST_SQ && $past(cnt_reg) == SQ_LAST)
        else $error("heat multiply loaded before the square finished");

endmodule
